FILE: rtl/vptw_pkg.sv
// shared types, constants and helpers for the vertex projection block
package vptw_pkg;

    typedef enum logic {
        OP_LOAD,
        OP_PROJECT
    } op_t;

    localparam logic FUNC_PROJECT = 1'b1;

    localparam logic [7:0] CFG_VP_X = 8'd0;
    localparam logic [7:0] CFG_VP_Y = 8'd1;
    localparam logic [7:0] CFG_VP_W = 8'd2;
    localparam logic [7:0] CFG_VP_H = 8'd3;

    localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

    typedef struct packed {
        op_t                op;
        logic [4:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } viewport_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_COPY,
        ST_CHECK,
        ST_DSTART,
        ST_DIV,
        ST_DFIN,
        ST_MAP_MUL,
        ST_MAP_SUM,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/vertex_project_to_window.sv
// top level: viewport registers, input queue and compute engine
//
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid/in_stall   | func, entry_index, entry_value, point_x/y/z
//  out     | from block| out_valid/out_stall | projection_ok, win_x, win_y, win_z
//  cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a load beat is written straight into the matrix store from the idle state; a project beat
// runs two matrix passes through the shared multiplier (read, multiply, accumulate for each
// term) and one divide per coordinate in the one-bit-per-cycle divider
// reset restores both matrices to identity and clears the viewport
// a two-beat queue keeps taking input while the engine or the output register is stalled, until it is full
module vertex_project_to_window #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [4:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               projection_ok,
    output logic signed [31:0] win_x,
    output logic signed [31:0] win_y,
    output logic signed [31:0] win_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    vptw_pkg::viewport_t vp_reg, vp_next;
    logic                q_valid;
    logic                q_pop;
    vptw_pkg::item_t     q_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        vp_next = vp_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                vptw_pkg::CFG_VP_X: vp_next.x = $signed(cfg_data);
                vptw_pkg::CFG_VP_Y: vp_next.y = $signed(cfg_data);
                vptw_pkg::CFG_VP_W: vp_next.w = cfg_data[14:0];
                vptw_pkg::CFG_VP_H: vp_next.h = cfg_data[14:0];
                default:            vp_next   = vp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= '0;
        end
        else
        begin
            vp_reg <= vp_next;
        end
    end

    vptw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    vptw_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .vp            (vp_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .projection_ok (projection_ok),
        .win_x         (win_x),
        .win_y         (win_y),
        .win_z         (win_z)
    );

endmodule

FILE: rtl/vptw_ram.sv
// generic single-port-write ram with registered read
module vptw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/vptw_front.sv
// input side: decodes each beat and queues it for the compute engine
module vptw_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   func,
    input  logic [4:0]             entry_index,
    input  logic signed [31:0]     entry_value,
    input  logic signed [31:0]     point_x,
    input  logic signed [31:0]     point_y,
    input  logic signed [31:0]     point_z,
    output logic                   q_valid,
    output vptw_pkg::item_t        q_item,
    input  logic                   q_pop
);

    vptw_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    vptw_pkg::item_t item_in;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.op          = (func == vptw_pkg::FUNC_PROJECT) ? vptw_pkg::OP_PROJECT
                                                               : vptw_pkg::OP_LOAD;
        item_in.entry_index = entry_index;
        item_in.entry_value = entry_value;
        item_in.point_x     = point_x;
        item_in.point_y     = point_y;
        item_in.point_z     = point_z;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/vptw_back.sv
// compute engine: matrix store, shared multiply-accumulate, divider and viewport map
module vptw_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  vptw_pkg::item_t        q_item,
    output logic                   q_pop,
    input  vptw_pkg::viewport_t    vp,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   projection_ok,
    output logic signed [31:0]     win_x,
    output logic signed [31:0]     win_y,
    output logic signed [31:0]     win_z
);

    localparam int NB = 32 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    vptw_pkg::state_t state_reg, state_next;
    logic [4:0]          step_reg, step_next;
    logic [31:0]         valid_reg, valid_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_ident_reg, rd_ident_next;
    logic signed [31:0]  vec_reg [4];
    logic signed [31:0]  vec_next [4];
    logic signed [31:0]  res_reg [4];
    logic signed [31:0]  res_next [4];
    logic signed [31:0]  win_reg [3];
    logic signed [31:0]  win_next [3];
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [65:0]  acc_reg, acc_next;
    logic [1:0]          coord_reg, coord_next;
    logic [NB-1:0]       nq_reg, nq_next;
    logic [32:0]         rem_reg, rem_next;
    logic [31:0]         dmag_reg, dmag_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic signed [31:0]  q_reg, q_next;
    logic signed [48:0]  t_reg, t_next;
    logic                ok_reg, ok_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;
    logic signed [31:0]  out_x_reg, out_x_next;
    logic signed [31:0]  out_y_reg, out_y_next;
    logic signed [31:0]  out_z_reg, out_z_next;

    logic                ram_we;
    logic [4:0]          ram_raddr;
    logic [31:0]         ram_rdata;

    logic [4:0]          ent_addr;
    logic signed [31:0]  m_sel;
    logic signed [63:0]  p_full;
    logic signed [65:0]  sum;
    logic [31:0]         bmag;
    logic [32:0]         rem_sh;
    logic                ge;
    logic signed [NB:0]  sq;
    logic signed [71:0]  wide;
    logic signed [32:0]  qp1;
    logic signed [15:0]  size_sel;
    logic signed [15:0]  org_sel;
    logic signed [71:0]  org_sh;

    vptw_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_item.entry_index),
        .wdata (q_item.entry_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign projection_ok = out_ok_reg;
    assign win_x         = out_x_reg;
    assign win_y         = out_y_reg;
    assign win_z         = out_z_reg;

    // step is {pass, row, col}; entry address is {pass, col, row}
    assign ent_addr  = {step_reg[4], step_reg[1:0], step_reg[3:2]};
    assign ram_raddr = ent_addr;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        valid_next     = valid_reg;
        rd_valid_next  = rd_valid_reg;
        rd_ident_next  = rd_ident_reg;
        vec_next       = vec_reg;
        res_next       = res_reg;
        win_next       = win_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        coord_next     = coord_reg;
        nq_next        = nq_reg;
        rem_next       = rem_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        t_next         = t_reg;
        ok_next        = ok_reg;
        out_ok_next    = out_ok_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        ram_we         = 1'b0;

        // unregistered entries read as identity
        m_sel  = rd_valid_reg ? $signed(ram_rdata) : (rd_ident_reg ? ONE : 32'sd0);
        p_full = m_sel * vec_reg[step_reg[1:0]];
        sum    = acc_reg + 66'(prod_reg);
        if (step_reg[1:0] == 2'd0)
        begin
            sum = 66'(prod_reg);
        end
        bmag   = res_reg[coord_reg][31] ? 32'(-res_reg[coord_reg]) : res_reg[coord_reg];
        rem_sh = {rem_reg[31:0], nq_reg[NB-1]};
        ge     = (rem_sh >= {1'b0, dmag_reg});
        sq     = neg_reg ? -$signed({1'b0, nq_reg}) : $signed({1'b0, nq_reg});
        wide   = 72'(sq);
        qp1    = 33'(q_reg) + 33'(ONE);
        size_sel = (coord_reg == 2'd0) ? $signed({1'b0, vp.w}) :
                   (coord_reg == 2'd1) ? $signed({1'b0, vp.h}) : 16'sd1;
        org_sel  = (coord_reg == 2'd0) ? vp.x : (coord_reg == 2'd1) ? vp.y : 16'sd0;
        org_sh   = 72'(org_sel) <<< FRAC_BITS;

        unique case (state_reg)
            vptw_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == vptw_pkg::OP_LOAD)
                    begin
                        ram_we = 1'b1;
                        valid_next[q_item.entry_index] = 1'b1;
                    end
                    else
                    begin
                        vec_next[0] = q_item.point_x;
                        vec_next[1] = q_item.point_y;
                        vec_next[2] = q_item.point_z;
                        vec_next[3] = ONE;
                        step_next   = 5'd0;
                        state_next  = vptw_pkg::ST_READ;
                    end
                end
            end
            vptw_pkg::ST_READ:
            begin
                rd_valid_next = valid_reg[ent_addr];
                rd_ident_next = (ent_addr[3:0] == 4'd0) || (ent_addr[3:0] == 4'd5) ||
                                (ent_addr[3:0] == 4'd10) || (ent_addr[3:0] == 4'd15);
                state_next    = vptw_pkg::ST_MUL;
            end
            vptw_pkg::ST_MUL:
            begin
                prod_next  = p_full >>> FRAC_BITS;
                state_next = vptw_pkg::ST_ACC;
            end
            vptw_pkg::ST_ACC:
            begin
                acc_next  = sum;
                step_next = step_reg + 5'd1;
                if (step_reg[1:0] == 2'd3)
                begin
                    res_next[step_reg[3:2]] = vptw_pkg::sat32(72'(sum));
                end
                if (step_reg == 5'd15)
                begin
                    state_next = vptw_pkg::ST_COPY;
                end
                else if (step_reg == 5'd31)
                begin
                    state_next = vptw_pkg::ST_CHECK;
                end
                else
                begin
                    state_next = vptw_pkg::ST_READ;
                end
            end
            vptw_pkg::ST_COPY:
            begin
                vec_next   = res_reg;
                state_next = vptw_pkg::ST_READ;
            end
            vptw_pkg::ST_CHECK:
            begin
                coord_next = 2'd0;
                dmag_next  = res_reg[3][31] ? 32'(-res_reg[3]) : res_reg[3];
                if (res_reg[3] == 32'sd0)
                begin
                    ok_next    = 1'b0;
                    win_next[0] = 32'sd0;
                    win_next[1] = 32'sd0;
                    win_next[2] = 32'sd0;
                    state_next = vptw_pkg::ST_OUT;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = vptw_pkg::ST_DSTART;
                end
            end
            vptw_pkg::ST_DSTART:
            begin
                nq_next    = {bmag, {FRAC_BITS{1'b0}}};
                rem_next   = 33'd0;
                neg_next   = res_reg[coord_reg][31] ^ res_reg[3][31];
                cnt_next   = CW'(NB);
                state_next = vptw_pkg::ST_DIV;
            end
            vptw_pkg::ST_DIV:
            begin
                rem_next = ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
                nq_next  = {nq_reg[NB-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = vptw_pkg::ST_DFIN;
                end
            end
            vptw_pkg::ST_DFIN:
            begin
                q_next     = vptw_pkg::sat32(wide);
                state_next = vptw_pkg::ST_MAP_MUL;
            end
            vptw_pkg::ST_MAP_MUL:
            begin
                t_next     = qp1 * size_sel;
                state_next = vptw_pkg::ST_MAP_SUM;
            end
            vptw_pkg::ST_MAP_SUM:
            begin
                win_next[coord_reg] = vptw_pkg::sat32(72'(t_reg >>> 1) + org_sh);
                if (coord_reg == 2'd2)
                begin
                    state_next = vptw_pkg::ST_OUT;
                end
                else
                begin
                    coord_next = coord_reg + 2'd1;
                    state_next = vptw_pkg::ST_DSTART;
                end
            end
            vptw_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_x_next     = win_reg[0];
                    out_y_next     = win_reg[1];
                    out_z_next     = win_reg[2];
                    state_next     = vptw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vptw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= rd_valid_next;
        rd_ident_reg <= rd_ident_next;
        vec_reg      <= vec_next;
        res_reg      <= res_next;
        win_reg      <= win_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        coord_reg    <= coord_next;
        nq_reg       <= nq_next;
        rem_reg      <= rem_next;
        dmag_reg     <= dmag_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        q_reg        <= q_next;
        t_reg        <= t_next;
        ok_reg       <= ok_next;
        step_reg     <= step_next;
        out_ok_reg   <= out_ok_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_z_reg    <= out_z_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vptw_pkg::ST_IDLE;
            valid_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: verif/tb.sv
// testbench for vertex_project_to_window: directed and random phases checked against a built-in predictor
module tb;

    localparam int FRAC = 16;
    localparam logic signed [31:0] ONE = 32'sd65536;
    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int PRESSURE_PHASE = 4;

    typedef struct {
        logic               ok;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } window_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               func;
    logic [4:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               out_valid;
    logic               out_stall;
    logic               projection_ok;
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] win_z;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [15:0]        cfg_data;

    vptw_pkg::item_t    pending[$];
    window_t            window_q[$];
    logic signed [31:0] modelview[16];
    logic signed [31:0] projection[16];
    logic signed [15:0] vp_x;
    logic signed [15:0] vp_y;
    logic [14:0]        vp_w;
    logic [14:0]        vp_h;
    int                 errors;
    int                 quiet;
    int                 in_idle_pct;
    int                 out_stall_pct;
    int                 phase_id;
    int                 hold_left;
    bit                 hold_done;
    logic               in_took;

    vertex_project_to_window DUT (.*);

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic window_t project_point(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic signed [31:0] pz);
        longint  v[4];
        longint  a[4];
        longint  b[4];
        longint  acc;
        longint  q[3];
        window_t r;
        v[0] = longint'(px);
        v[1] = longint'(py);
        v[2] = longint'(pz);
        v[3] = longint'(ONE);
        for (int row = 0; row < 4; row++)
        begin
            acc = 0;
            for (int col = 0; col < 4; col++)
            begin
                acc += (longint'(modelview[col * 4 + row]) * v[col]) >>> FRAC;
            end
            a[row] = clamp32(acc);
        end
        for (int row = 0; row < 4; row++)
        begin
            acc = 0;
            for (int col = 0; col < 4; col++)
            begin
                acc += (longint'(projection[col * 4 + row]) * a[col]) >>> FRAC;
            end
            b[row] = clamp32(acc);
        end
        r = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
        if (b[3] != 0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q[k] = clamp32((b[k] * longint'(ONE)) / b[3]);
            end
            r.ok = 1'b1;
            r.x = 32'(clamp32((((q[0] + ONE) * longint'(vp_w)) >>> 1)
                              + longint'(vp_x) * ONE));
            r.y = 32'(clamp32((((q[1] + ONE) * longint'(vp_h)) >>> 1)
                              + longint'(vp_y) * ONE));
            r.z = 32'(clamp32((q[2] + ONE) >>> 1));
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // input and output beats, config writes, prediction and checking
    always @(posedge clk)
    begin
        window_t w;
        in_took <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    vptw_pkg::CFG_VP_X: vp_x = cfg_data;
                    vptw_pkg::CFG_VP_Y: vp_y = cfg_data;
                    vptw_pkg::CFG_VP_W: vp_w = cfg_data[14:0];
                    vptw_pkg::CFG_VP_H: vp_h = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (func == vptw_pkg::FUNC_PROJECT)
                begin
                    window_q.insert(window_q.size(), project_point(point_x, point_y, point_z));
                end
                else if (entry_index[4])
                begin
                    projection[entry_index[3:0]] = entry_value;
                end
                else
                begin
                    modelview[entry_index[3:0]] = entry_value;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (window_q.size() == 0)
                begin
                    report("unexpected beat", win_x, 32'h0);
                end
                else
                begin
                    w = window_q.pop_front();
                    if (projection_ok !== w.ok)
                    begin
                        report("projection_ok", 32'(projection_ok), 32'(w.ok));
                    end
                    if (win_x !== w.x)
                    begin
                        report("win_x", win_x, w.x);
                    end
                    if (win_y !== w.y)
                    begin
                        report("win_y", win_y, w.y);
                    end
                    if (win_z !== w.z)
                    begin
                        report("win_z", win_z, w.z);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                quiet <= 0;
            end
            else if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        vptw_pkg::item_t cur;
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending.size() > 0 && $urandom_range(1, 100) > in_idle_pct)
            begin
                cur = pending.pop_front();
                in_valid <= 1'b1;
                func <= cur.op;
                entry_index <= cur.entry_index;
                entry_value <= cur.entry_value;
                point_x <= cur.point_x;
                point_y <= cur.point_y;
                point_z <= cur.point_z;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall, with one long hold-off in the pressure phase
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (phase_id == PRESSURE_PHASE && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(1, 100) <= out_stall_pct);
            end
        end
    end

    function automatic vptw_pkg::item_t load_item(input logic [4:0] idx,
                                                  input logic signed [31:0] val);
        vptw_pkg::item_t it;
        it.op = vptw_pkg::OP_LOAD;
        it.entry_index = idx;
        it.entry_value = val;
        it.point_x = $urandom;
        it.point_y = $urandom;
        it.point_z = $urandom;
        return it;
    endfunction

    function automatic vptw_pkg::item_t project_item(input logic signed [31:0] px,
                                                     input logic signed [31:0] py,
                                                     input logic signed [31:0] pz);
        vptw_pkg::item_t it;
        it.op = vptw_pkg::OP_PROJECT;
        it.entry_index = 5'($urandom);
        it.entry_value = $urandom;
        it.point_x = px;
        it.point_y = py;
        it.point_z = pz;
        return it;
    endfunction

    function automatic logic signed [31:0] near_value(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic add_item(input vptw_pkg::item_t it);
        pending.insert(pending.size(), it);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_viewport(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] w, input logic [15:0] h);
        write_reg(vptw_pkg::CFG_VP_X, x);
        write_reg(vptw_pkg::CFG_VP_Y, y);
        write_reg(vptw_pkg::CFG_VP_W, w);
        write_reg(vptw_pkg::CFG_VP_H, h);
    endtask

    task automatic drain();
        while (pending.size() != 0 || in_valid || window_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic add_random(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                // zero clip w, then restore
                for (int k = 19; k <= 31; k += 4)
                begin
                    add_item(load_item(5'(k), 32'sd0));
                end
                add_item(project_item(near_value(1 << 24), near_value(1 << 24),
                                      near_value(1 << 24)));
                add_item(load_item(5'd31, ONE));
            end
            else if (r < 28)
            begin
                add_item(load_item(5'($urandom), near_value(4 << 16)));
            end
            else if (r < 33)
            begin
                add_item(load_item(5'($urandom), $urandom));
            end
            else if (r < 85)
            begin
                add_item(project_item(near_value(256 << 16), near_value(256 << 16),
                                      near_value(256 << 16)));
            end
            else
            begin
                add_item(project_item($urandom, $urandom, $urandom));
            end
        end
    endtask

    initial
    begin
        int idle_in[5] = '{0, 88, 0, 28, 0};
        int idle_out[5] = '{0, 0, 88, 28, 0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = 1'b0;
        entry_index = '0;
        entry_value = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        quiet = 0;
        in_took = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        phase_id = 0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        for (int i = 0; i < 16; i++)
        begin
            modelview[i] = (i % 5 == 0) ? ONE : 32'sd0;
            projection[i] = (i % 5 == 0) ? ONE : 32'sd0;
        end
        vp_x = '0;
        vp_y = '0;
        vp_w = '0;
        vp_h = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset viewport, extremes, zero w, ignored fields
        add_item(project_item(ONE, -ONE, ONE));
        drain();
        set_viewport(16'hFFF6, 16'd20, 16'd640, 16'd480);
        write_reg(8'd7, 16'hFFFF);
        add_item(project_item(32'sd0, 32'sd0, 32'sd0));
        add_item(project_item(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        add_item(project_item(32'sh80000000, 32'sh80000000, 32'sh80000000));
        add_item(project_item(ONE, -ONE, 32'sh00008000));
        add_item(load_item(5'd0, 32'sh7FFFFFFF));
        add_item(load_item(5'd5, 32'sh80000000));
        add_item(project_item(32'sh7FFFFFFF, 32'sh80000000, ONE));
        add_item(load_item(5'd0, ONE));
        add_item(load_item(5'd5, ONE));
        add_item(load_item(5'd31, 32'sd0));
        add_item(project_item(ONE, ONE, ONE));
        add_item(load_item(5'd31, ONE >>> 1));
        add_item(project_item(3 * ONE, -2 * ONE, ONE >>> 2));
        add_item(load_item(5'd31, ONE));
        add_item(load_item(5'd12, 5 * ONE));
        add_item(load_item(5'd28, -3 * ONE));
        add_item(project_item(-ONE, ONE, -ONE));
        add_item(load_item(5'd12, 32'sd0));
        add_item(load_item(5'd28, 32'sd0));
        drain();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: set_viewport(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000);
                1: set_viewport(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF);
                2: set_viewport(16'd0, 16'd0, 16'd1920, 16'd1080);
                default: set_viewport(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom));
            endcase
            in_idle_pct = idle_in[p];
            out_stall_pct = idle_out[p];
            phase_id = p;
            add_random(p == PRESSURE_PHASE ? 80 : 95);
            drain();
        end

        if (errors == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: vertex_project_to_window.f
rtl/vptw_pkg.sv
rtl/vptw_ram.sv
rtl/vptw_front.sv
rtl/vptw_back.sv
rtl/vertex_project_to_window.sv
verif/tb.sv
